### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the positional list block.
// No dependencies; SYNTH empties the macros for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked on every clock edge outside reset.
`define POL_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define POL_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define POL_ASSERT(label, clk, rst, prop, msg)
`define POL_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### rtl/pol_pkg.sv
// Package for the positional list block: field widths, operation codes,
// and the command and result structs. No dependencies.
package pol_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int OP_W  = 2;
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int LEN_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_RETRIEVE = 2'd2,
    OP_SEARCH   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                     operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] data;
    logic [POS_W-1:0]        found_position;
    logic [LEN_W-1:0]        length;
  } rsp_t;

endpackage

### rtl/pol_if.sv
// Valid/ready channel interfaces for the positional list block.
// Depends on pol_pkg for field widths.
interface pol_cmd_if;
  import pol_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, operation, position, value, input ready);
  modport sink   (input valid, operation, position, value, output ready);
endinterface

interface pol_rsp_if;
  import pol_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    ok;
  logic signed [VAL_W-1:0] data;
  logic [POS_W-1:0]        found_position;
  logic [LEN_W-1:0]        length;

  modport source (output valid, ok, data, found_position, length, input ready);
  modport sink   (input valid, ok, data, found_position, length, output ready);
endinterface

### rtl/pol_store.sv
// Entry cells and entry count of the positional list, with the one-pass
// insert/remove/retrieve/search logic. Depends on pol_pkg, assert_macros.svh.
`include "assert_macros.svh"

module pol_store #(
  parameter int CAPACITY = pol_pkg::CAPACITY_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  pol_pkg::cmd_t cmd,
  output pol_pkg::rsp_t rsp
);
  import pol_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  logic [VAL_W-1:0] entries      [CAPACITY];
  logic [VAL_W-1:0] entries_next [CAPACITY];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic [CMP_W-1:0] pos_w, cnt_w, slot;
  logic             pos_nz;
  logic             ins_ok, rem_ok, get_ok, srch_ok;
  logic [CAPACITY-1:0] hit;
  logic [IDX_W-1:0] where;

  // Range checks on the requested position
  always_comb begin
    pos_w   = CMP_W'(cmd.position);
    cnt_w   = CMP_W'(count);
    slot    = pos_w - CMP_W'(1);
    pos_nz  = (pos_w != '0);
    ins_ok  = (cmd.operation == OP_INSERT) && pos_nz &&
              (pos_w <= cnt_w + CMP_W'(1)) && (cnt_w < CMP_W'(CAPACITY));
    rem_ok  = (cmd.operation == OP_REMOVE) && pos_nz && (pos_w <= cnt_w);
    get_ok  = (cmd.operation == OP_RETRIEVE) && pos_nz && (pos_w <= cnt_w);
  end

  // Per-cell compare and shift
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic below, at;

    always_comb begin
      below  = CMP_W'(g) < slot;
      at     = CMP_W'(g) == slot;
      hit[g] = (CMP_W'(g) < cnt_w) && (entries[g] == cmd.value);
      entries_next[g] = entries[g];
      if (ins_ok) begin
        if (at) begin
          entries_next[g] = cmd.value;
        end else if (!below) begin
          if (g > 0) entries_next[g] = entries[(g > 0) ? g - 1 : 0];
        end
      end else if (rem_ok && !below) begin
        if (g < CAPACITY - 1) entries_next[g] = entries[(g < CAPACITY - 1) ? g + 1 : g];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) entries[g] <= entries_next[g];
    end
  end

  // First matching cell wins
  always_comb begin
    srch_ok = (cmd.operation == OP_SEARCH) && (|hit);
    where = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hit[i]) where = IDX_W'(i);
    end
  end

  // Count update and result fields
  always_comb begin
    count_next = count;
    if (ins_ok) count_next = count + CNT_W'(1);
    else if (rem_ok) count_next = count - CNT_W'(1);

    rsp.ok             = ins_ok || rem_ok || get_ok || srch_ok;
    rsp.data           = get_ok ? entries[slot[IDX_W-1:0]] : '0;
    rsp.found_position = srch_ok ? POS_W'(CMP_W'(where) + CMP_W'(1)) : '0;
    rsp.length         = LEN_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (advance) begin
      count <= count_next;
    end
  end

  `POL_ASSERT(a_count_bound, clk, rst, (count <= CNT_W'(CAPACITY)), "entry count above capacity")
  `POL_ASSERT(a_insert_grows, clk, rst, (advance && ins_ok |=> count == $past(count) + CNT_W'(1)), "insert did not grow the list")
  `POL_ASSERT(a_remove_shrinks, clk, rst, (advance && rem_ok |=> count == $past(count) - CNT_W'(1)), "remove did not shrink the list")
  `POL_ASSERT(a_idle_holds, clk, rst, (!advance |=> $stable(count)), "count changed without an item")

endmodule

### rtl/positional_ordered_list.sv
// Positional list: an ordered list of up to CAPACITY signed 32-bit values
// with 1-based positions, supporting insert, remove, retrieve and search.
// Each item is registered on entry, worked in one pass by compare and
// shift logic in every entry cell, and its result lands in an output
// register: one item per cycle unless the result stalls, which holds the
// item in the input register. Throughput is set by that one pass across
// all cells. Out-of-range positions and full-list inserts answer ok=0
// and leave the list unchanged. Depends on pol_pkg, pol_if, pol_store.
`include "assert_macros.svh"

module positional_ordered_list #(
  parameter int CAPACITY = pol_pkg::CAPACITY_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  pol_cmd_if.sink   cmd,
  pol_rsp_if.source rsp
);
  import pol_pkg::*;

  cmd_t cmd_q;
  logic cmd_valid;
  rsp_t rsp_q;
  rsp_t rsp_next;
  logic rsp_valid;
  logic rsp_free;
  logic advance;

  // Stage handshake
  assign rsp_free  = !rsp_valid || rsp.ready;
  assign advance   = cmd_valid && rsp_free;
  assign cmd.ready = !cmd_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (cmd.ready) begin
      cmd_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      cmd_q.operation <= op_t'(cmd.operation);
      cmd_q.position  <= cmd.position;
      cmd_q.value     <= cmd.value;
    end
  end

  pol_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cmd     (cmd_q),
    .rsp     (rsp_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_free) begin
      rsp_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) rsp_q <= rsp_next;
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.ok             = rsp_q.ok;
  assign rsp.data           = rsp_q.data;
  assign rsp.found_position = rsp_q.found_position;
  assign rsp.length         = rsp_q.length;

  `POL_ASSERT(a_take_fills, clk, rst, (cmd.valid && cmd.ready |=> cmd_valid), "accepted item lost before compute")
  `POL_ASSERT(a_adv_result, clk, rst, (advance |=> rsp_valid), "computed item gave no result")
  `POL_ASSERT_ALWAYS(a_reset_empty, clk, ($past(rst) |-> !rsp_valid && !cmd_valid), "pipeline not empty after reset")

endmodule

### tb/sv/positional_ordered_list_tb.sv
// Self-checking testbench for positional_ordered_list: insert, remove, retrieve
// and search items are predicted by a local list model and checked per field.
// Depends on pol_pkg, pol_cmd_if, pol_rsp_if and the positional_ordered_list RTL.
module positional_ordered_list_tb;
  import pol_pkg::*;

  localparam int CAPACITY   = CAPACITY_DEFAULT;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;
  localparam int MAX_PRINTS  = 30;

  logic clk;
  logic rst;

  pol_cmd_if cmd_ch ();
  pol_rsp_if rsp_ch ();

  positional_ordered_list #(.CAPACITY(CAPACITY)) uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // List model and the answers it still owes
  logic signed [VAL_W-1:0] list_vals [CAPACITY];
  int                      list_len;
  rsp_t                    pending_answers [$];

  // Tallies and control
  int error_count;
  int result_count;
  int op_tally [4];
  int refused_count;
  int search_hits;
  int peak_len;
  int idle_cycles;
  int planned_len;
  int hold_left;
  int stall_left;
  bit idle_on;
  bit growing;
  logic signed [VAL_W-1:0] value_pool [8];

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one operation to the list model and return the answer it gives
  function automatic rsp_t apply_list_op(cmd_t c);
    rsp_t r;
    int   p;
    r = '0;
    p = int'(c.position);
    case (c.operation)
      OP_INSERT: begin
        if (p >= 1 && p <= list_len + 1 && list_len < CAPACITY) begin
          for (int i = list_len; i >= p; i--) list_vals[i] = list_vals[i-1];
          list_vals[p-1] = c.value;
          list_len++;
          r.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (p >= 1 && p <= list_len) begin
          for (int i = p; i < list_len; i++) list_vals[i-1] = list_vals[i];
          list_len--;
          r.ok = 1'b1;
        end
      end
      OP_RETRIEVE: begin
        if (p >= 1 && p <= list_len) begin
          r.data = list_vals[p-1];
          r.ok   = 1'b1;
        end
      end
      default: begin
        for (int i = 0; i < list_len; i++) begin
          if (list_vals[i] === c.value) begin
            r.found_position = POS_W'(i + 1);
            r.ok             = 1'b1;
            break;
          end
        end
      end
    endcase
    r.length = LEN_W'(list_len);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("MISMATCH result %0d %s: got %0h expected %0h", result_count, field, got, want);
  endtask

  // Monitor: predicts on each accepted command, checks each accepted result
  always @(posedge clk) begin
    cmd_t c;
    rsp_t got;
    rsp_t want;
    bit   moved;
    if (!rst) begin
      moved = 1'b0;
      if (cmd_ch.valid && cmd_ch.ready) begin
        c.operation = op_t'(cmd_ch.operation);
        c.position  = cmd_ch.position;
        c.value     = cmd_ch.value;
        want = apply_list_op(c);
        pending_answers.push_back(want);
        op_tally[c.operation]++;
        if (c.operation == OP_INSERT && !want.ok && list_len == CAPACITY) refused_count++;
        if (c.operation == OP_SEARCH && want.ok) search_hits++;
        if (list_len > peak_len) peak_len = list_len;
        moved = 1'b1;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.ok             = rsp_ch.ok;
        got.data           = rsp_ch.data;
        got.found_position = rsp_ch.found_position;
        got.length         = rsp_ch.length;
        result_count++;
        if (pending_answers.size() == 0) begin
          report_mismatch("result with nothing expected", '0, '0);
        end else begin
          want = pending_answers.pop_front();
          if (got.ok !== want.ok) report_mismatch("ok", VAL_W'(got.ok), VAL_W'(want.ok));
          if (got.data !== want.data) report_mismatch("data", got.data, want.data);
          if (got.found_position !== want.found_position)
            report_mismatch("found_position", VAL_W'(got.found_position),
                            VAL_W'(want.found_position));
          if (got.length !== want.length)
            report_mismatch("length", VAL_W'(got.length), VAL_W'(want.length));
        end
        moved = 1'b1;
      end
      // Watchdog on cycles with no handshake at all
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles, %0d results owed",
                 STALL_LIMIT, pending_answers.size());
        $display("positional_ordered_list verification failed");
        $finish;
      end
    end
  end

  // Result side: random stall bursts plus an optional long hold-off
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 10);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one command item and hold it until accepted
  task automatic send_item(op_t op, logic [POS_W-1:0] pos, logic signed [VAL_W-1:0] val);
    cmd_ch.valid     <= 1'b1;
    cmd_ch.operation <= op;
    cmd_ch.position  <= pos;
    cmd_ch.value     <= val;
    do @(posedge clk); while (!cmd_ch.ready);
    // track the length the stimulus expects, to aim positions in range
    if (op == OP_INSERT && pos >= 1 && pos <= planned_len + 1 && planned_len < CAPACITY)
      planned_len++;
    else if (op == OP_REMOVE && pos >= 1 && pos <= planned_len)
      planned_len--;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 1) == 0) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // One random operation, mostly well aimed, sometimes out of range
  task automatic send_random_op();
    op_t              op;
    int               r;
    int               bias;
    logic [POS_W-1:0] pos;
    bias = growing ? 60 : 25;
    r = $urandom_range(0, 99);
    if (r < bias) op = OP_INSERT;
    else if (r < bias + (100 - bias) / 2) op = OP_REMOVE;
    else if (r % 2 == 0) op = OP_RETRIEVE;
    else op = OP_SEARCH;
    if ($urandom_range(0, 9) == 0 || op == OP_SEARCH)
      pos = POS_W'($urandom_range(0, 31));
    else if (op == OP_INSERT)
      pos = POS_W'($urandom_range(1, planned_len + 1));
    else if (planned_len == 0)
      pos = POS_W'($urandom_range(0, 31));
    else
      pos = POS_W'($urandom_range(1, planned_len));
    send_item(op, pos, pick_value());
    if (planned_len >= CAPACITY) growing = 1'b0;
    else if (planned_len == 0) growing = 1'b1;
    else if ($urandom_range(0, 39) == 0) growing = !growing;
  endtask

  // Every operation against an empty list
  task automatic test_empty_list();
    send_item(OP_RETRIEVE, 5'd0, 32'sd0);
    send_item(OP_REMOVE, 5'd1, 32'sd0);
    send_item(OP_SEARCH, 5'd0, 32'sd0);
    send_item(OP_INSERT, 5'd2, 32'sd7);
  endtask

  // Fill to capacity at front, middle and end, then probe the limits
  task automatic test_fill_and_limits();
    send_item(OP_INSERT, 5'd1, 32'sh7FFF_FFFF);
    send_item(OP_INSERT, 5'd1, 32'sh8000_0000);
    send_item(OP_INSERT, 5'd3, -32'sd1);
    send_item(OP_INSERT, 5'd2, 32'sd0);
    while (planned_len < CAPACITY)
      send_item(OP_INSERT, POS_W'($urandom_range(1, planned_len + 1)), pick_value());
    // full list refuses even an in-range position
    send_item(OP_INSERT, 5'd17, 32'sd3);
    send_item(OP_RETRIEVE, 5'd16, 32'sd0);
    send_item(OP_SEARCH, 5'd31, 32'sh8000_0000);
    send_item(OP_SEARCH, 5'd0, 32'sh5A5A_A5A5);
    send_item(OP_REMOVE, 5'd31, 32'sd0);
    send_item(OP_REMOVE, 5'd16, 32'sd0);
    send_item(OP_REMOVE, 5'd1, 32'sd0);
  endtask

  task automatic test_random_ops(int count);
    repeat (count) send_random_op();
  endtask

  // Receiver holds off while commands keep coming, so the input stalls
  task automatic test_result_backpressure();
    hold_left = HOLD_CYCLES;
    repeat (40) send_random_op();
  endtask

  task automatic finish_run();
    cmd_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Test sequence
  initial begin
    rst              <= 1'b1;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.operation <= OP_INSERT;
    cmd_ch.position  <= '0;
    cmd_ch.value     <= '0;
    list_len     = 0;
    planned_len  = 0;
    hold_left    = 0;
    stall_left   = 0;
    idle_on      = 1'b1;
    growing      = 1'b1;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7FFF_FFFF;
    value_pool[2] = 32'sd0;
    value_pool[3] = -32'sd1;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_list();
    test_fill_and_limits();
    test_random_ops(240);
    test_result_backpressure();
    // last stretch runs back to back on both sides
    idle_on = 1'b0;
    test_random_ops(230);
    finish_run();

    $display("Ran %0d items: %0d insert, %0d remove, %0d retrieve, %0d search; %0d results",
             op_tally[OP_INSERT] + op_tally[OP_REMOVE] + op_tally[OP_RETRIEVE] +
             op_tally[OP_SEARCH], op_tally[OP_INSERT],
             op_tally[OP_REMOVE], op_tally[OP_RETRIEVE], op_tally[OP_SEARCH], result_count);
    $display("Peak length %0d, %0d inserts refused on a full list, %0d search hits, %0d errors",
             peak_len, refused_count, search_hits, error_count);
    if (error_count == 0) begin
      $display("positional_ordered_list verification clean");
    end else begin
      $display("positional_ordered_list verification failed");
    end
    $finish;
  end

endmodule
